### design/kdm_pkg.sv
// Shared types, field widths, masks and codes for the key debounce macro player.
// No dependencies; used by kdm_debounce, kdm_macro and the top level.
package kdm_pkg;

  localparam int KEY_W       = 22;
  localparam int PAD_W       = 11;
  localparam int ADDR_W      = 10;
  localparam int OPC_W       = 2;
  localparam int OPND_W      = 16;
  localparam int WORD_W      = OPC_W + OPND_W;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 80;

  localparam int PROGRAM_DEPTH_DEF = 1024;

  localparam logic [KEY_W-1:0] KEY_ALL_MASK = 22'h3F07FF;
  localparam int               KEY_BACK1_BIT = 16;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [OPC_W-1:0] OP_DRIVE = 2'd0;
  localparam logic [OPC_W-1:0] OP_WAIT  = 2'd1;
  localparam logic [OPC_W-1:0] OP_JUMP  = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key_state;
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] released;
  } deb_res_t;

  typedef struct packed {
    logic              tick;
    logic              wr;
    logic              back_press;
    logic              back_release;
    logic [ADDR_W-1:0] addr;
    logic [OPC_W-1:0]  opcode;
    logic [OPND_W-1:0] operand;
  } mac_req_t;

  typedef struct packed {
    logic [PAD_W-1:0] drive_keys;
    logic             running;
    logic             busy;
  } mac_res_t;

endpackage

### design/kdm_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module kdm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/kdm_debounce.sv
// Two-sample key debouncer with press and release edge detection.
// Depends on kdm_pkg.
module kdm_debounce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic [kdm_pkg::KEY_W-1:0] raw_keys_i,
  output kdm_pkg::deb_res_t         res_o
);
  import kdm_pkg::*;

  logic [KEY_W-1:0] older_q, newer_q, deb_q;
  logic [KEY_W-1:0] older_d, newer_d, deb_d;
  logic [KEY_W-1:0] hi, lo, set_keys, pressed, released;

  always_comb begin
    older_d  = newer_q;
    newer_d  = raw_keys_i;
    hi       = older_d & newer_d;
    lo       = ~(older_d | newer_d);
    pressed  = ~deb_q & hi & KEY_ALL_MASK;
    set_keys = deb_q | hi;
    released = set_keys & lo & KEY_ALL_MASK;
    deb_d    = set_keys & ~lo & KEY_ALL_MASK;
    if (tick_i) begin
      res_o.key_state = deb_d;
      res_o.pressed   = pressed;
      res_o.released  = released;
    end else begin
      res_o.key_state = deb_q;
      res_o.pressed   = '0;
      res_o.released  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      deb_q   <= '0;
    end else if (tick_i) begin
      older_q <= older_d;
      newer_q <= newer_d;
      deb_q   <= deb_d;
    end
  end

endmodule

### design/kdm_macro.sv
// Macro sequencer: program store with clearing sweep, program counter, wait counter.
// Depends on kdm_pkg and kdm_ram.
module kdm_macro #(
  parameter int PROGRAM_DEPTH = kdm_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kdm_pkg::mac_req_t req_i,
  output kdm_pkg::mac_res_t res_o
);
  import kdm_pkg::*;

  localparam int PW = $clog2(PROGRAM_DEPTH);
  localparam int AX = (PW > ADDR_W) ? PW : ADDR_W;

  logic              run_q, run_d;
  logic [PW-1:0]     pc_q, pc_d, pc_inc, pc_jump;
  logic [OPND_W-1:0] wc_q, wc_d, wc_inc;
  logic [PAD_W-1:0]  drv_q, drv_d;
  logic              clr_q;
  logic [PW-1:0]     clr_cnt_q;
  logic              fwd_q;
  logic [WORD_W-1:0] fwd_data_q;

  logic              we;
  logic [PW-1:0]     waddr;
  logic [WORD_W-1:0] wdata, rdata, word;
  logic [OPC_W-1:0]  opc;
  logic [OPND_W-1:0] opnd;
  logic              addr_ok, wait_done;
  logic [PW+1:0]     jsum, j1, j2;

  logic [PW-1:0] neg_hi [256];
  logic [PW-1:0] neg_lo [256];

  // (-operand) mod depth, split by operand byte
  for (genvar g = 0; g < 256; g++) begin : g_jtab
    localparam int HiVal = (g < 128) ? g * 256 : g * 256 - 65536;
    localparam int NegHi = (((-HiVal) % PROGRAM_DEPTH) + PROGRAM_DEPTH) % PROGRAM_DEPTH;
    localparam int NegLo = (PROGRAM_DEPTH - (g % PROGRAM_DEPTH)) % PROGRAM_DEPTH;
    assign neg_hi[g] = PW'(NegHi);
    assign neg_lo[g] = PW'(NegLo);
  end

  assign addr_ok = ((AX+1)'(req_i.addr) < (AX+1)'(PROGRAM_DEPTH));
  assign we      = clr_q | (req_i.wr & addr_ok);
  assign waddr   = clr_q ? clr_cnt_q : PW'(req_i.addr);
  assign wdata   = clr_q ? '0 : {req_i.opcode, req_i.operand};

  kdm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PROGRAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (pc_d),
    .rdata_o (rdata)
  );

  assign word = fwd_q ? fwd_data_q : rdata;
  assign opc  = word[WORD_W-1:OPND_W];
  assign opnd = word[OPND_W-1:0];

  always_comb begin
    pc_inc    = (pc_q == PW'(PROGRAM_DEPTH - 1)) ? '0 : pc_q + 1'b1;
    jsum      = (PW+2)'(pc_q) + (PW+2)'(1) + (PW+2)'(neg_hi[opnd[15:8]])
              + (PW+2)'(neg_lo[opnd[7:0]]);
    j1        = (jsum >= (PW+2)'(PROGRAM_DEPTH)) ? jsum - (PW+2)'(PROGRAM_DEPTH) : jsum;
    j2        = (j1 >= (PW+2)'(PROGRAM_DEPTH)) ? j1 - (PW+2)'(PROGRAM_DEPTH) : j1;
    pc_jump   = PW'(j2);
    wc_inc    = wc_q + 1'b1;
    wait_done = opnd[OPND_W-1] | (wc_inc >= opnd);

    run_d = run_q;
    pc_d  = pc_q;
    wc_d  = wc_q;
    drv_d = drv_q;
    if (req_i.tick) begin
      if (!run_q) begin
        if (req_i.back_press) begin
          run_d = 1'b1;
          pc_d  = '0;
          wc_d  = '0;
        end
      end else if (req_i.back_release) begin
        run_d = 1'b0;
        drv_d = '0;
      end else begin
        unique case (opc)
          OP_DRIVE: begin
            drv_d = opnd[PAD_W-1:0];
            pc_d  = pc_inc;
          end
          OP_WAIT: begin
            if (wait_done) begin
              wc_d = '0;
              pc_d = pc_inc;
            end else begin
              wc_d = wc_inc;
            end
          end
          OP_JUMP: pc_d = pc_jump;
          OP_NOP:  pc_d = pc_inc;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      pc_q      <= '0;
      wc_q      <= '0;
      drv_q     <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      fwd_q     <= 1'b0;
    end else begin
      run_q <= run_d;
      pc_q  <= pc_d;
      wc_q  <= wc_d;
      drv_q <= drv_d;
      fwd_q <= we & (waddr == pc_d);
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == PW'(PROGRAM_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
  end

  assign res_o.drive_keys = drv_d;
  assign res_o.running    = run_d;
  assign res_o.busy       = clr_q;

endmodule

### design/key_debounce_macro_player_top.sv
// Top level of the key debounce macro player: stream ports, input and result registers.
// Depends on kdm_pkg, kdm_debounce, kdm_macro (and kdm_ram below it).
//
// channel  dir  tdata fields (low bit up)                          tuser
// s_axis   in   raw_keys 22, prog_address 10, prog_opcode 2,       command
//               prog_operand 16 (signed), pad 6
// m_axis   out  key_state 22, pressed_edges 22, released_edges 22, none
//               report_change 1, drive_keys 11, macro_running 1, pad 1
//
// One word per cycle sustained while the output is ready and no clearing sweep runs;
// each input word passes through the input register, then the result register.
// The program store is read one entry ahead through its registered port, with write
// forwarding. After reset a clearing sweep zeroes every entry of the store; the input
// stays not ready until the sweep ends. A stalled output holds its result and
// takes one more word into the input register before backing up.
module key_debounce_macro_player_top #(
  parameter int PROGRAM_DEPTH = kdm_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [kdm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // raw_keys, addr, opcode, operand
  input  logic                            s_axis_tuser,  // command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [kdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // state, pressed, released,
                                                         // change, drive, running
);
  import kdm_pkg::*;

  logic              in_valid_q;
  logic              in_cmd_q;
  logic [KEY_W-1:0]  in_raw_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic [OPC_W-1:0]  in_opc_q;
  logic [OPND_W-1:0] in_opnd_q;

  logic              out_valid_q;
  deb_res_t          out_deb_q;
  logic              out_chg_q;
  logic [PAD_W-1:0]  out_drv_q;
  logic              out_run_q;

  logic              adv, take, tick;
  deb_res_t          deb;
  mac_req_t          req;
  mac_res_t          mac;

  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~mac.busy & (~in_valid_q | adv);
  assign take          = s_axis_tvalid & s_axis_tready;
  assign tick          = adv & (in_cmd_q == CMD_TICK);

  kdm_debounce u_deb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .raw_keys_i (in_raw_q),
    .res_o      (deb)
  );

  always_comb begin
    req.tick         = tick;
    req.wr           = adv & (in_cmd_q == CMD_WRITE);
    req.back_press   = deb.pressed[KEY_BACK1_BIT];
    req.back_release = deb.released[KEY_BACK1_BIT];
    req.addr         = in_addr_q;
    req.opcode       = in_opc_q;
    req.operand      = in_opnd_q;
  end

  kdm_macro #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (mac)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_cmd_q  <= s_axis_tuser;
      in_raw_q  <= s_axis_tdata[21:0];
      in_addr_q <= s_axis_tdata[31:22];
      in_opc_q  <= s_axis_tdata[33:32];
      in_opnd_q <= s_axis_tdata[49:34];
    end
    if (adv) begin
      out_deb_q <= deb;
      out_chg_q <= |(deb.pressed | deb.released);
      out_drv_q <= mac.drive_keys;
      out_run_q <= mac.running;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_run_q, out_drv_q, out_chg_q, out_deb_q.released,
                          out_deb_q.pressed, out_deb_q.key_state};

  a_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac.busy |-> !s_axis_tready)
    else $error("input taken during store clearing sweep");

  a_idle_drives_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_run_q) |-> (out_drv_q == '0))
    else $error("keys driven while macro idle");

  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_deb_q.pressed & out_deb_q.released) == '0))
    else $error("key pressed and released on the same tick");

  a_write_no_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_cmd_q == CMD_WRITE) |=> !out_chg_q)
    else $error("edge reported on a program write");

endmodule
